@@ rtl/bjos_pkg.sv @@
package bjos_pkg;

   localparam int MAX_JOBS = 16;
   localparam int CNT_W    = $clog2(MAX_JOBS + 1);
   localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

   localparam int ID_W    = 8;
   localparam int BURST_W = 8;
   localparam int PRIO_W  = 4;
   localparam int KEY_W   = 8;
   localparam int TIME_W  = 12;
   localparam int MODE_W  = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int Q_PTR_W     = 2;
   localparam int Q_CNT_W     = 3;

   localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SJF  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PRIO = 2'd2;

   // one classified request on its way to the scheduler
   typedef struct packed {
      logic               store;
      logic               last;
      logic [ID_W-1:0]    id;
      logic [BURST_W-1:0] burst;
      logic [KEY_W-1:0]   key;
   } job_entry_type;

endpackage

@@ rtl/bjos_front.sv @@
module bjos_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bjos_pkg::ID_W-1:0]      req_job_id,
   input  logic [bjos_pkg::BURST_W-1:0]   req_burst_len,
   input  logic [bjos_pkg::PRIO_W-1:0]    req_prio_level,
   input  logic                           req_last_job,
   input  logic [bjos_pkg::MODE_W-1:0]    policy_mode,
   output logic                           push_valid,
   input  logic                           push_ready,
   output bjos_pkg::job_entry_type        push_data
);
   import bjos_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             room;
   logic             accept;
   logic [KEY_W-1:0] key;

   assign room      = (count_ff != CNT_W'(MAX_JOBS));
   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   // a request past capacity is taken and dropped unless it closes the batch
   assign push_valid = req_valid && (room || req_last_job);

   always_comb begin
      unique case (policy_mode)
         MODE_SJF:  key = KEY_W'(req_burst_len);
         MODE_PRIO: key = KEY_W'(req_prio_level);
         default:   key = '0;
      endcase
   end

   assign push_data.store = room;
   assign push_data.last  = req_last_job;
   assign push_data.id    = req_job_id;
   assign push_data.burst = req_burst_len;
   assign push_data.key   = key;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (req_last_job) begin
            count_in = '0;
         end else if (room) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/bjos_queue.sv @@
module bjos_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  bjos_pkg::job_entry_type push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output bjos_pkg::job_entry_type pop_data
);
   import bjos_pkg::*;

   job_entry_type      slot_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff;
   logic [Q_PTR_W-1:0] rd_ptr_ff;
   logic [Q_CNT_W-1:0] used_ff;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (used_ff != Q_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (used_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + Q_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            used_ff <= used_ff + Q_CNT_W'(1);
         end else if (do_pop && !do_push) begin
            used_ff <= used_ff - Q_CNT_W'(1);
         end
      end
   end

endmodule

@@ rtl/bjos_back.sv @@
module bjos_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  bjos_pkg::job_entry_type        pop_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bjos_pkg::ID_W-1:0]      rsp_out_job_id,
   output logic [bjos_pkg::TIME_W-1:0]    rsp_wait_time,
   output logic [bjos_pkg::TIME_W-1:0]    rsp_finish_time,
   output logic                           rsp_last_result
);
   import bjos_pkg::*;

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } back_state_type;

   back_state_type     state_ff, state_in;

   logic [ID_W-1:0]    store_id_ff    [MAX_JOBS];
   logic [BURST_W-1:0] store_burst_ff [MAX_JOBS];
   logic [KEY_W-1:0]   store_key_ff   [MAX_JOBS];

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    emitted_ff, emitted_in;
   logic [IDX_W-1:0]    scan_ff, scan_in;
   logic                found_ff, found_in;
   logic [KEY_W-1:0]    best_key_ff, best_key_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [ID_W-1:0]     best_id_ff, best_id_in;
   logic [BURST_W-1:0]  best_burst_ff, best_burst_in;
   logic [MAX_JOBS-1:0] served_ff, served_in;
   logic [TIME_W-1:0]   clock_ff, clock_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]     rsp_id_ff;
   logic [TIME_W-1:0]   rsp_wait_ff;
   logic [TIME_W-1:0]   rsp_finish_ff;
   logic                rsp_last_ff;

   logic                do_pop;
   logic                do_store;
   logic                scan_last;
   logic                take;
   logic                out_free;
   logic                emit;
   logic                final_job;
   logic [TIME_W-1:0]   finish;

   assign pop_ready = (state_ff == ST_LOAD);
   assign do_pop    = pop_valid && pop_ready;
   assign do_store  = do_pop && pop_data.store;

   assign scan_last = (CNT_W'(scan_ff) + CNT_W'(1)) == count_ff;
   // strict compare keeps the earliest arrival on a tie
   assign take      = !served_ff[scan_ff] &&
                      (!found_ff || (store_key_ff[scan_ff] < best_key_ff));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = (state_ff == ST_EMIT) && out_free;
   assign final_job = (emitted_ff + CNT_W'(1)) == count_ff;
   assign finish    = clock_ff + TIME_W'(best_burst_ff);

   always_ff @(posedge clock) begin
      if (do_store) begin
         store_id_ff[count_ff[IDX_W-1:0]]    <= pop_data.id;
         store_burst_ff[count_ff[IDX_W-1:0]] <= pop_data.burst;
         store_key_ff[count_ff[IDX_W-1:0]]   <= pop_data.key;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      emitted_in    = emitted_ff;
      scan_in       = scan_ff;
      found_in      = found_ff;
      best_key_in   = best_key_ff;
      best_idx_in   = best_idx_ff;
      best_id_in    = best_id_ff;
      best_burst_in = best_burst_ff;
      served_in     = served_ff;
      clock_in      = clock_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_LOAD: begin
            if (do_pop) begin
               if (pop_data.store) begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (pop_data.last) begin
                  state_in = ST_SCAN;
                  scan_in  = '0;
                  found_in = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (take) begin
               found_in      = 1'b1;
               best_key_in   = store_key_ff[scan_ff];
               best_idx_in   = scan_ff;
               best_id_in    = store_id_ff[scan_ff];
               best_burst_in = store_burst_ff[scan_ff];
            end
            if (scan_last) begin
               state_in = ST_EMIT;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               served_in    = served_ff | (MAX_JOBS'(1) << best_idx_ff);
               clock_in     = finish;
               emitted_in   = emitted_ff + CNT_W'(1);
               if (final_job) begin
                  // batch done: clear and go back to loading
                  state_in   = ST_LOAD;
                  count_in   = '0;
                  emitted_in = '0;
                  served_in  = '0;
                  clock_in   = '0;
               end else begin
                  state_in = ST_SCAN;
                  scan_in  = '0;
                  found_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         emitted_ff   <= '0;
         scan_ff      <= '0;
         found_ff     <= 1'b0;
         served_ff    <= '0;
         clock_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         emitted_ff   <= emitted_in;
         scan_ff      <= scan_in;
         found_ff     <= found_in;
         served_ff    <= served_in;
         clock_ff     <= clock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_key_ff   <= best_key_in;
      best_idx_ff   <= best_idx_in;
      best_id_ff    <= best_id_in;
      best_burst_ff <= best_burst_in;
      if (emit) begin
         rsp_id_ff     <= best_id_ff;
         rsp_wait_ff   <= clock_ff;
         rsp_finish_ff <= finish;
         rsp_last_ff   <= final_job;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_job_id  = rsp_id_ff;
   assign rsp_wait_time   = rsp_wait_ff;
   assign rsp_finish_time = rsp_finish_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

@@ rtl/batch_job_order_scheduler.sv @@
// Batch job scheduler.
// Request channel (req_*): one job per request, with id, burst length and
// priority; req_last_job closes the batch and starts the schedule. Jobs past
// the store capacity are accepted and dropped; a dropped request that closes
// the batch still starts the schedule of what is stored.
// Response channel (rsp_*): one response per stored job, in run order, with
// its id, start (wait) time and finish time; rsp_last_result marks the last.
// csr_*: policy_mode write port, always ready; 0 arrival order, 1 shortest
// burst first, 2 lowest priority number first, 3 as arrival order. Write it
// only while no batch is in flight.
// A request passes a 4-entry queue and is then written to the job
// store. For each response of a batch the selection scan goes over the
// job store, one stored job at a time, picks the next job to run and then
// issues it as the response.
// Requests keep flowing into the queue while a batch is scheduled; req_ready
// drops once the queue is full. A stalled response holds in the output
// register; the next job is still selected, then waits for the register.
// Reset clears the queue, the batch and the policy (arrival order).
module batch_job_order_scheduler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bjos_pkg::ID_W-1:0]      req_job_id,
   input  logic [bjos_pkg::BURST_W-1:0]   req_burst_len,
   input  logic [bjos_pkg::PRIO_W-1:0]    req_prio_level,
   input  logic                           req_last_job,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bjos_pkg::ID_W-1:0]      rsp_out_job_id,
   output logic [bjos_pkg::TIME_W-1:0]    rsp_wait_time,
   output logic [bjos_pkg::TIME_W-1:0]    rsp_finish_time,
   output logic                           rsp_last_result,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bjos_pkg::MODE_W-1:0]    csr_policy_mode
);
   import bjos_pkg::*;

   logic [MODE_W-1:0] mode_ff;
   logic              push_valid;
   logic              push_ready;
   job_entry_type     push_data;
   logic              pop_valid;
   logic              pop_ready;
   job_entry_type     pop_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_FCFS;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_policy_mode;
      end
   end

   bjos_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_job_id     (req_job_id),
      .req_burst_len  (req_burst_len),
      .req_prio_level (req_prio_level),
      .req_last_job   (req_last_job),
      .policy_mode    (mode_ff),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   bjos_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   bjos_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_job_id  (rsp_out_job_id),
      .rsp_wait_time   (rsp_wait_time),
      .rsp_finish_time (rsp_finish_time),
      .rsp_last_result (rsp_last_result)
   );

endmodule

@@ rtl/bjos_checker.sv @@
module bjos_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [bjos_pkg::ID_W-1:0]      rsp_out_job_id,
   input logic [bjos_pkg::TIME_W-1:0]    rsp_wait_time,
   input logic [bjos_pkg::TIME_W-1:0]    rsp_finish_time,
   input logic                           rsp_last_result
);
   import bjos_pkg::*;

   logic              in_batch_ff;
   logic [TIME_W-1:0] prev_finish_ff;

   // track where the next response of a batch must start
   always_ff @(posedge clock) begin
      if (reset) begin
         in_batch_ff    <= 1'b0;
         prev_finish_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         in_batch_ff    <= !rsp_last_result;
         prev_finish_ff <= rsp_finish_time;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_job_id) &&
      $stable(rsp_wait_time) && $stable(rsp_finish_time) && $stable(rsp_last_result))
      else $error("response changed while stalled");

   a_first_at_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !in_batch_ff |-> rsp_wait_time == '0)
      else $error("first job of a batch does not start at zero");

   a_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && in_batch_ff |-> rsp_wait_time == prev_finish_ff)
      else $error("job does not start when the previous one finished");

   a_finish_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_finish_time >= rsp_wait_time)
      else $error("finish time before start time");

endmodule

bind batch_job_order_scheduler bjos_checker u_bjos_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_job_id  (rsp_out_job_id),
   .rsp_wait_time   (rsp_wait_time),
   .rsp_finish_time (rsp_finish_time),
   .rsp_last_result (rsp_last_result)
);
